@@ hdl/isbe_pkg.sv @@
`timescale 1ns / 1ps

package isbe_pkg;

  localparam int MAX_BASES  = 24;
  localparam int KNOT_DEPTH = 32;
  localparam int FRAC_BITS  = 16;

  localparam int COEF_DEPTH = MAX_BASES + 1;
  localparam int KA_W       = $clog2(KNOT_DEPTH);
  localparam int CA_W       = $clog2(COEF_DEPTH);
  // B-spline values stay below 8.0 at order four
  localparam int NW         = FRAC_BITS + 4;
  localparam int DD_W       = 32 + NW;

  localparam logic [FRAC_BITS:0] ONE_FX = (FRAC_BITS + 1)'(1) << FRAC_BITS;

  typedef enum logic [1:0] {
    CMD_KNOT = 2'd0,
    CMD_COEF = 2'd1,
    CMD_EVAL = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_KNOT_RD,
    ST_SUPP,
    ST_TERM,
    ST_DGO,
    ST_DWAIT,
    ST_STORE,
    ST_OUT_C0,
    ST_OUT_RD,
    ST_OUT_MUL,
    ST_OUT_ACC
  } st_e;

  typedef struct packed {
    logic            knot_we;
    logic [KA_W-1:0] knot_waddr;
    logic            coef_we;
    logic [CA_W-1:0] coef_waddr;
    logic [31:0]     wdata;
    logic            knot_re;
    logic [KA_W-1:0] knot_raddr;
    logic            coef_re;
    logic [CA_W-1:0] coef_raddr;
  } mem_req_t;

endpackage

@@ hdl/i_spline_basis_evaluation.sv @@
`timescale 1ns / 1ps
// channel    | handshake                | payload
// -----------+--------------------------+-------------------------------------------
// request    | start in, busy out       | command_i, table_index_i, value_i
// result     | valid_o strobe, no stall | basis_index_o, basis_value_o,
//            |                          | curve_value_o, last_o
// config     | cfg_valid_i, cfg_ready_o | cfg_data_i (num_bases)
//
// Knot and coefficient writes are done from idle and never raise busy.
// An evaluate request walks the knot table to find the interval over the single
// knot read port, runs 24 recursion steps (knot reads, then up to two divisions
// each), then emits one basis result per coefficient read.
// Reset is asynchronous; tables hold garbage until written, num_bases resets to 4.
// Results leave one per strobe and cannot be held off.

module i_spline_basis_evaluation (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         command_i,
  input  logic [4:0]         table_index_i,
  input  logic signed [31:0] value_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [4:0]         cfg_data_i,
  output logic               valid_o,
  output logic [4:0]         basis_index_o,
  output logic [16:0]        basis_value_o,
  output logic signed [40:0] curve_value_o,
  output logic               last_o
);
  import isbe_pkg::*;

  st_e state_q, state_d;

  logic [4:0]         num_bases_q;
  logic signed [31:0] x_q;
  logic [4:0]         nb_q;
  logic [4:0]         cnt_q;
  logic [4:0]         j_q;
  logic [2:0]         lvl_q;
  logic [2:0]         pos_q;
  logic [2:0]         rd_q;
  logic [31:0]        kn_q [4];
  logic               term_q;
  logic [NW-1:0]      acc_q;
  logic [DD_W-1:0]    prod_q;
  logic [31:0]        den_q;
  logic [NW-1:0]      ring_q [6];
  logic [4:0]         oi_q;
  logic [FRAC_BITS:0] b_q;
  logic signed [49:0] cprod_q;
  logic signed [40:0] curve_q;

  mem_req_t    req;
  logic [31:0] knot_rdata;
  logic [31:0] coef_rdata;
  logic        div_done;
  logic [NW-1:0] div_quot;

  logic        accept;
  logic [4:0]  nb_eff;
  logic [4:0]  lk;

  logic signed [6:0] ib;
  logic signed [6:0] kidx;

  logic signed [32:0] xe, tie, tik1e, ti1e, tke;
  logic signed [32:0] l1, l2, da, db;
  logic        supp;
  logic [31:0] m_a;
  logic [NW-1:0] m_n;
  logic signed [32:0] m_l;
  logic        need;

  logic signed [6:0] dj;
  logic [NW+1:0] isum;
  logic [FRAC_BITS:0] bval;
  logic signed [40:0] curve_n;

  function automatic logic [KA_W-1:0] kclamp(input logic signed [6:0] v);
    if (v < 7'sd0) begin
      return '0;
    end else if (v > $signed(7'(KNOT_DEPTH - 1))) begin
      return KA_W'(KNOT_DEPTH - 1);
    end else begin
      return KA_W'(v);
    end
  endfunction

  isbe_store u_store (
    .clk_i       (clk_i),
    .req_i       (req),
    .knot_rdata_o(knot_rdata),
    .coef_rdata_o(coef_rdata)
  );

  isbe_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (state_q == ST_DGO),
    .dividend_i(prod_q),
    .divisor_i (den_q),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  assign busy        = state_q != ST_IDLE;
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;
  assign nb_eff      = (num_bases_q > 5'(MAX_BASES)) ? 5'(MAX_BASES) : num_bases_q;
  assign lk          = nb_q + 5'd5;

  assign ib = $signed({2'b00, j_q}) - 7'sd2 + $signed({4'b0000, pos_q});

  always_comb begin
    unique case (rd_q)
      3'd0:    kidx = ib;
      3'd1:    kidx = ib + $signed({4'b0000, lvl_q}) - 7'sd1;
      3'd2:    kidx = ib + 7'sd1;
      default: kidx = ib + $signed({4'b0000, lvl_q});
    endcase
  end

  // kn_q order: t[i], t[i+k-1], t[i+1], t[i+k]
  assign xe    = {x_q[31], x_q};
  assign tie   = {kn_q[0][31], kn_q[0]};
  assign tik1e = {kn_q[1][31], kn_q[1]};
  assign ti1e  = {kn_q[2][31], kn_q[2]};
  assign tke   = {kn_q[3][31], kn_q[3]};
  assign supp  = (xe >= tie) && (xe < tke);
  assign l1    = tik1e - tie;
  assign l2    = tke - ti1e;
  assign da    = xe - tie;
  assign db    = tke - xe;
  assign m_a   = term_q ? db[31:0] : da[31:0];
  assign m_n   = term_q ? ring_q[1] : ring_q[0];
  assign m_l   = term_q ? l2 : l1;
  assign need  = (m_n != '0) && (m_l > 33'sd0);

  always_comb begin
    dj = $signed({2'b00, j_q}) - $signed({2'b00, oi_q});
    unique case (dj)
      7'sd0:   isum = (NW + 2)'(ring_q[2]);
      7'sd1:   isum = (NW + 2)'(ring_q[1]) + (NW + 2)'(ring_q[2]);
      7'sd2:   isum = (NW + 2)'(ring_q[0]) + (NW + 2)'(ring_q[1]) + (NW + 2)'(ring_q[2]);
      default: isum = (dj < 7'sd0) ? '0 : (NW + 2)'(ONE_FX);
    endcase
    if (isum > (NW + 2)'(ONE_FX)) begin
      bval = '0;
    end else begin
      bval = ONE_FX - (FRAC_BITS + 1)'(isum);
    end
  end

  assign curve_n = curve_q + 41'(cprod_q >>> FRAC_BITS);

  always_comb begin
    req            = '0;
    req.wdata      = value_i;
    req.knot_waddr = KA_W'(table_index_i);
    req.coef_waddr = CA_W'(table_index_i);
    req.knot_we    = accept && (command_i == CMD_KNOT) && (6'(table_index_i) < 6'(KNOT_DEPTH));
    req.coef_we    = accept && (command_i == CMD_COEF) && (6'(table_index_i) < 6'(COEF_DEPTH));
    req.knot_raddr = kclamp(kidx);
    req.coef_raddr = CA_W'(oi_q);
    state_d        = state_q;
    valid_o        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (command_i == CMD_EVAL) && (nb_eff != 5'd0)) begin
          state_d = ST_SRCH_RD;
        end
      end
      ST_SRCH_RD: begin
        req.knot_raddr = KA_W'(cnt_q);
        if (cnt_q == lk) begin
          state_d = ST_KNOT_RD;
        end else begin
          req.knot_re = 1'b1;
          state_d     = ST_SRCH_CMP;
        end
      end
      ST_SRCH_CMP: begin
        state_d = ($signed(knot_rdata) <= x_q) ? ST_SRCH_RD : ST_KNOT_RD;
      end
      ST_KNOT_RD: begin
        req.knot_re = rd_q != 3'd4;
        if (rd_q == 3'd4) begin
          state_d = ST_SUPP;
        end
      end
      ST_SUPP: begin
        state_d = (!supp || lvl_q == 3'd1) ? ST_STORE : ST_TERM;
      end
      ST_TERM: begin
        if (need) begin
          state_d = ST_DGO;
        end else if (term_q) begin
          state_d = ST_STORE;
        end
      end
      ST_DGO: state_d = ST_DWAIT;
      ST_DWAIT: begin
        if (div_done) begin
          state_d = term_q ? ST_STORE : ST_TERM;
        end
      end
      ST_STORE: begin
        state_d = (pos_q == 3'd5 && lvl_q == 3'd4) ? ST_OUT_C0 : ST_KNOT_RD;
      end
      ST_OUT_C0: begin
        req.coef_re    = 1'b1;
        req.coef_raddr = '0;
        state_d        = ST_OUT_RD;
      end
      ST_OUT_RD: begin
        req.coef_re = 1'b1;
        state_d     = ST_OUT_MUL;
      end
      ST_OUT_MUL: state_d = ST_OUT_ACC;
      ST_OUT_ACC: begin
        valid_o = 1'b1;
        state_d = (oi_q == nb_q) ? ST_IDLE : ST_OUT_RD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign basis_index_o = oi_q;
  assign basis_value_o = b_q;
  assign last_o        = oi_q == nb_q;
  assign curve_value_o = last_o ? curve_n : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      num_bases_q <= 5'd4;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        num_bases_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        x_q   <= value_i;
        nb_q  <= nb_eff;
        cnt_q <= 5'd1;
        lvl_q <= 3'd1;
        pos_q <= '0;
        rd_q  <= '0;
      end
      ST_SRCH_RD: begin
        if (cnt_q == lk) begin
          j_q <= cnt_q - 5'd1;
        end
      end
      ST_SRCH_CMP: begin
        if ($signed(knot_rdata) <= x_q) begin
          cnt_q <= cnt_q + 5'd1;
        end else begin
          j_q <= cnt_q - 5'd1;
        end
      end
      ST_KNOT_RD: begin
        if (rd_q != 3'd0) begin
          kn_q[0] <= kn_q[1];
          kn_q[1] <= kn_q[2];
          kn_q[2] <= kn_q[3];
          kn_q[3] <= knot_rdata;
        end
        rd_q <= (rd_q == 3'd4) ? 3'd0 : rd_q + 3'd1;
      end
      ST_SUPP: begin
        acc_q  <= (supp && lvl_q == 3'd1) ? NW'(ONE_FX) : '0;
        term_q <= 1'b0;
      end
      ST_TERM: begin
        if (need) begin
          prod_q <= DD_W'(m_a) * DD_W'(m_n);
          den_q  <= m_l[31:0];
        end else begin
          term_q <= 1'b1;
        end
      end
      ST_DWAIT: begin
        if (div_done) begin
          acc_q  <= acc_q + div_quot;
          term_q <= 1'b1;
        end
      end
      ST_STORE: begin
        for (int r = 0; r < 5; r++) begin
          ring_q[r] <= ring_q[r+1];
        end
        ring_q[5] <= acc_q;
        if (pos_q == 3'd5) begin
          pos_q <= '0;
          lvl_q <= lvl_q + 3'd1;
        end else begin
          pos_q <= pos_q + 3'd1;
        end
      end
      ST_OUT_C0: oi_q <= 5'd1;
      ST_OUT_RD: begin
        if (oi_q == 5'd1) begin
          curve_q <= 41'($signed(coef_rdata));
        end
        b_q <= bval;
      end
      ST_OUT_MUL: begin
        cprod_q <= 50'($signed(coef_rdata)) * 50'($signed({1'b0, b_q}));
      end
      ST_OUT_ACC: begin
        curve_q <= curve_n;
        oi_q    <= oi_q + 5'd1;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hdl/isbe_store.sv @@
`timescale 1ns / 1ps

module isbe_store (
  input  logic               clk_i,
  input  isbe_pkg::mem_req_t req_i,
  output logic [31:0]        knot_rdata_o,
  output logic [31:0]        coef_rdata_o
);
  import isbe_pkg::*;

  logic [31:0] knot_mem [KNOT_DEPTH];
  logic [31:0] coef_mem [COEF_DEPTH];

  always_ff @(posedge clk_i) begin
    if (req_i.knot_we) begin
      knot_mem[req_i.knot_waddr] <= req_i.wdata;
    end
    if (req_i.knot_re) begin
      knot_rdata_o <= knot_mem[req_i.knot_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.coef_we) begin
      coef_mem[req_i.coef_waddr] <= req_i.wdata;
    end
    if (req_i.coef_re) begin
      coef_rdata_o <= coef_mem[req_i.coef_raddr];
    end
  end

endmodule

@@ hdl/isbe_div.sv @@
`timescale 1ns / 1ps

module isbe_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [isbe_pkg::DD_W-1:0] dividend_i,
  input  logic [31:0]               divisor_i,
  output logic                      done_o,
  output logic [isbe_pkg::NW-1:0]   quot_o
);
  import isbe_pkg::*;

  localparam int CW = $clog2(NW + 1);

  logic [DD_W-1:0] rem_q;
  logic [DD_W-1:0] dsh_q;
  logic [NW-1:0]   quot_q;
  logic [CW-1:0]   cnt_q;
  logic            run_q;
  logic            done_q;
  logic            fits;

  assign fits   = rem_q >= dsh_q;
  assign done_o = done_q;
  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(NW);
      end else if (run_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dividend_i;
      dsh_q  <= DD_W'({divisor_i, {(NW - 1){1'b0}}});
      quot_q <= '0;
    end else if (run_q) begin
      if (fits) begin
        rem_q <= rem_q - dsh_q;
      end
      quot_q <= {quot_q[NW-2:0], fits};
      dsh_q  <= dsh_q >> 1;
    end
  end

endmodule
